### hdl/onpd_pkg.sv
// shared constants, field widths and controller/datapath command types
// for the online nearest point distance core; no dependencies
package onpd_pkg;

    localparam int GRID_ROWS_DEF  = 64;
    localparam int GRID_COLS_DEF  = 64;
    localparam int MAX_RECENT_DEF = 64;

    localparam int COORD_W    = 6;
    localparam int DIST_OUT_W = 7;
    localparam int IVAL_W     = 7;
    localparam int PHASE_W    = 6;
    localparam logic [IVAL_W-1:0] IVAL_RESET = 7'd8;
    localparam logic [DIST_OUT_W-1:0] DIST_OUT_MAX = 7'd127;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic load;
        logic rd_cur;
        logic take_grid;
        logic scan;
        logic put;
        logic sweep_start;
        logic sweep;
        logic src_rd;
        logic src_grid;
        logic src_chk;
        logic pop;
        logic pop_data;
        logic nb;
        logic add_recent;
        logic finish;
    } onpd_cmd_t;

    typedef struct packed {
        logic first;
        logic scan_done;
        logic out_free;
        logic need_rebuild;
        logic sweep_done;
        logic src_last;
        logic q_nonempty;
        logic nb_done;
    } onpd_status_t;

endpackage

### hdl/onpd_ctrl.sv
// controller state machine of the nearest point distance core
// depends on onpd_pkg for the command and status structs
module onpd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  onpd_pkg::onpd_status_t status,
    output onpd_pkg::onpd_cmd_t    cmd
);
    import onpd_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOOK   = 4'd1;
    localparam logic [3:0] ST_GRIDD  = 4'd2;
    localparam logic [3:0] ST_SCAN   = 4'd3;
    localparam logic [3:0] ST_OUT    = 4'd4;
    localparam logic [3:0] ST_DECIDE = 4'd5;
    localparam logic [3:0] ST_SWEEP  = 4'd6;
    localparam logic [3:0] ST_SRC_R  = 4'd7;
    localparam logic [3:0] ST_SRC_G  = 4'd8;
    localparam logic [3:0] ST_SRC_C  = 4'd9;
    localparam logic [3:0] ST_POP    = 4'd10;
    localparam logic [3:0] ST_POPD   = 4'd11;
    localparam logic [3:0] ST_NB     = 4'd12;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (status.first) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.rd_cur = 1'b1;
                    state_next = ST_GRIDD;
                end
            end
            ST_GRIDD: begin
                cmd.take_grid = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.put = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.need_rebuild) begin
                    cmd.sweep_start = 1'b1;
                    state_next = ST_SWEEP;
                end else begin
                    cmd.add_recent = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (status.sweep_done) state_next = ST_SRC_R;
            end
            ST_SRC_R: begin
                cmd.src_rd = 1'b1;
                state_next = ST_SRC_G;
            end
            ST_SRC_G: begin
                cmd.src_grid = 1'b1;
                state_next = ST_SRC_C;
            end
            ST_SRC_C: begin
                cmd.src_chk = 1'b1;
                state_next = status.src_last ? ST_POP : ST_SRC_R;
            end
            ST_POP: begin
                if (status.q_nonempty) begin
                    cmd.pop = 1'b1;
                    state_next = ST_POPD;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POPD: begin
                cmd.pop_data = 1'b1;
                state_next = ST_NB;
            end
            ST_NB: begin
                cmd.nb = 1'b1;
                if (status.nb_done) state_next = ST_POP;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/onpd_dp.sv
// datapath of the nearest point distance core: distance grid, bfs queue,
// recent point list, scan and bfs arithmetic; depends on onpd_pkg
module onpd_dp #(
    parameter int GRID_ROWS  = onpd_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS  = onpd_pkg::GRID_COLS_DEF,
    parameter int MAX_RECENT = onpd_pkg::MAX_RECENT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  onpd_pkg::onpd_cmd_t                 cmd,
    output onpd_pkg::onpd_status_t              status,
    input  logic                                in_start,
    input  logic [onpd_pkg::COORD_W-1:0]        in_row,
    input  logic [onpd_pkg::COORD_W-1:0]        in_col,
    input  logic                                cfg_valid,
    input  logic [onpd_pkg::IVAL_W-1:0]         cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [onpd_pkg::DIST_OUT_W-1:0]     m_distance
);
    import onpd_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int QCW   = $clog2(CELLS + 1);
    localparam int DW    = $clog2(GRID_ROWS + GRID_COLS);
    localparam int RIW   = (MAX_RECENT > 1) ? $clog2(MAX_RECENT) : 1;
    localparam int RCW   = $clog2(MAX_RECENT + 1);
    localparam int QEW   = DW + RW + CW;
    localparam logic [DW-1:0] UNSEEN = '1;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        cell_addr = AW'(AW'(r) * AW'(GRID_COLS) + AW'(c));
    endfunction

    // memories
    logic [DW-1:0]      grid_mem [0:CELLS-1];
    logic [QEW-1:0]     queue_mem [0:CELLS-1];
    logic [RW+CW-1:0]   recent_mem [0:MAX_RECENT-1];
    logic [DW-1:0]      grid_q;
    logic [QEW-1:0]     queue_q;
    logic [RW+CW-1:0]   recent_q;

    logic [IVAL_W-1:0]  interval_reg;
    logic               first_reg, have_reg, rebuilt_reg, pend_reg, sw_end_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [RCW-1:0]     rc_reg, idx_reg;
    logic [RW-1:0]      cur_r_reg, p_r_reg, sw_r_reg, b_r_reg;
    logic [CW-1:0]      cur_c_reg, p_c_reg, sw_c_reg, b_c_reg;
    logic [DW-1:0]      best_reg, b_d_reg;
    logic [QCW-1:0]     head_reg, tail_reg;
    logic [2:0]         k_reg;
    logic               m_valid_reg;
    logic [DIST_OUT_W-1:0] m_data_reg;

    logic               keep;
    logic [RW-1:0]      rq_r, src_r, nr, in_r_sat;
    logic [CW-1:0]      rq_c, src_c, nc, in_c_sat;
    logic [RW-1:0]      dr;
    logic [CW-1:0]      dc;
    logic [DW-1:0]      rdist, nd;
    logic               nb_ok;
    logic [AW-1:0]      grid_raddr, grid_waddr, p_addr;
    logic               grid_we, q_push;
    logic [DW-1:0]      grid_wdata, q_push_d;
    logic [IVAL_W-1:0]  m_eff;
    logic [IVAL_W-1:0]  phase_inc;
    logic               sw_last;

    assign keep = !first_reg;
    assign rq_r = recent_q[RW+CW-1:CW];
    assign rq_c = recent_q[CW-1:0];
    assign src_r = (idx_reg == rc_reg) ? cur_r_reg : rq_r;
    assign src_c = (idx_reg == rc_reg) ? cur_c_reg : rq_c;
    assign p_addr = cell_addr(p_r_reg, p_c_reg);
    assign nd = b_d_reg + DW'(1);
    assign sw_last = (sw_r_reg == RW'(GRID_ROWS - 1)) && (sw_c_reg == CW'(GRID_COLS - 1));

    assign in_r_sat = (32'(in_row) >= GRID_ROWS) ? RW'(GRID_ROWS - 1) : RW'(in_row);
    assign in_c_sat = (32'(in_col) >= GRID_COLS) ? CW'(GRID_COLS - 1) : CW'(in_col);

    assign dr = (rq_r > cur_r_reg) ? rq_r - cur_r_reg : cur_r_reg - rq_r;
    assign dc = (rq_c > cur_c_reg) ? rq_c - cur_c_reg : cur_c_reg - rq_c;
    assign rdist = DW'(dr) + DW'(dc);

    // effective rebuild interval: zero acts as one, clamp at list size
    always_comb begin
        if (interval_reg == '0) begin
            m_eff = IVAL_W'(1);
        end else if (32'(interval_reg) > MAX_RECENT) begin
            m_eff = IVAL_W'(MAX_RECENT);
        end else begin
            m_eff = interval_reg;
        end
    end
    assign phase_inc = IVAL_W'(phase_reg) + IVAL_W'(1);

    // neighbor order: up, right, down, left
    always_comb begin
        nb_ok = 1'b0;
        nr = b_r_reg;
        nc = b_c_reg;
        case (k_reg)
            3'd0: begin
                nb_ok = (b_r_reg != '0);
                nr = b_r_reg - RW'(1);
            end
            3'd1: begin
                nb_ok = (b_c_reg != CW'(GRID_COLS - 1));
                nc = b_c_reg + CW'(1);
            end
            3'd2: begin
                nb_ok = (b_r_reg != RW'(GRID_ROWS - 1));
                nr = b_r_reg + RW'(1);
            end
            3'd3: begin
                nb_ok = (b_c_reg != '0);
                nc = b_c_reg - CW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.sweep) begin
            grid_raddr = cell_addr(sw_r_reg, sw_c_reg);
        end else if (cmd.src_grid) begin
            grid_raddr = cell_addr(src_r, src_c);
        end else if (cmd.nb) begin
            grid_raddr = cell_addr(nr, nc);
        end else begin
            grid_raddr = cell_addr(cur_r_reg, cur_c_reg);
        end
    end

    always_comb begin
        grid_we = 1'b0;
        grid_wdata = UNSEEN;
        q_push = 1'b0;
        q_push_d = '0;
        grid_waddr = p_addr;
        if (cmd.sweep && pend_reg) begin
            // old sources are the cells already at zero
            if (keep && grid_q == '0) begin
                q_push = 1'b1;
            end else begin
                grid_we = 1'b1;
            end
        end else if (cmd.src_chk && grid_q != '0) begin
            grid_we = 1'b1;
            grid_wdata = '0;
            q_push = 1'b1;
        end else if (cmd.nb && pend_reg && grid_q == UNSEEN && 32'(tail_reg) < CELLS) begin
            grid_we = 1'b1;
            grid_wdata = nd;
            q_push = 1'b1;
            q_push_d = nd;
        end
    end

    always_ff @(posedge aclk) begin
        if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
        if (cmd.rd_cur || cmd.sweep || cmd.src_grid || cmd.nb) begin
            grid_q <= grid_mem[grid_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) queue_mem[tail_reg[AW-1:0]] <= {q_push_d, p_r_reg, p_c_reg};
        queue_q <= queue_mem[head_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_recent) recent_mem[rc_reg[RIW-1:0]] <= {cur_r_reg, cur_c_reg};
        if (cmd.scan || cmd.src_rd) recent_q <= recent_mem[idx_reg[RIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= IVAL_RESET;
            first_reg    <= 1'b0;
            have_reg     <= 1'b0;
            rebuilt_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            sw_end_reg   <= 1'b0;
            phase_reg    <= '0;
            rc_reg       <= '0;
            idx_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) interval_reg <= cfg_data;
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (q_push) tail_reg <= tail_reg + QCW'(1);

            if (cmd.load) begin
                first_reg   <= in_start || !have_reg;
                rebuilt_reg <= 1'b0;
                if (in_start || !have_reg) begin
                    rc_reg    <= '0;
                    phase_reg <= '0;
                end
            end
            if (cmd.take_grid) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.scan) begin
                pend_reg <= (idx_reg < rc_reg);
                if (idx_reg < rc_reg) idx_reg <= idx_reg + RCW'(1);
            end
            if (cmd.put) m_valid_reg <= 1'b1;
            if (cmd.sweep_start) begin
                rebuilt_reg <= 1'b1;
                sw_end_reg  <= 1'b0;
                pend_reg    <= 1'b0;
                head_reg    <= '0;
                tail_reg    <= '0;
                idx_reg     <= '0;
            end
            if (cmd.sweep) begin
                pend_reg <= !sw_end_reg;
                if (!sw_end_reg && sw_last) sw_end_reg <= 1'b1;
            end
            if (cmd.src_chk) idx_reg <= idx_reg + RCW'(1);
            if (cmd.pop) head_reg <= head_reg + QCW'(1);
            if (cmd.pop_data) begin
                k_reg    <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.nb) begin
                pend_reg <= (k_reg < 3'd4) && nb_ok;
                if (k_reg < 3'd4) k_reg <= k_reg + 3'd1;
            end
            if (cmd.add_recent) rc_reg <= rc_reg + RCW'(1);
            if (cmd.finish) begin
                have_reg  <= 1'b1;
                phase_reg <= (phase_inc >= m_eff) ? '0 : phase_inc[PHASE_W-1:0];
                if (rebuilt_reg) rc_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_r_reg <= in_r_sat;
            cur_c_reg <= in_c_sat;
        end
        if (cmd.take_grid) best_reg <= grid_q;
        if (cmd.scan && pend_reg && rdist < best_reg) best_reg <= rdist;
        if (cmd.put) begin
            m_data_reg <= (32'(best_reg) > 32'(DIST_OUT_MAX)) ? DIST_OUT_MAX
                                                              : DIST_OUT_W'(best_reg);
        end
        if (cmd.sweep_start) begin
            sw_r_reg <= '0;
            sw_c_reg <= '0;
        end
        if (cmd.sweep && !sw_end_reg) begin
            p_r_reg <= sw_r_reg;
            p_c_reg <= sw_c_reg;
            if (sw_c_reg == CW'(GRID_COLS - 1)) begin
                sw_c_reg <= '0;
                sw_r_reg <= sw_r_reg + RW'(1);
            end else begin
                sw_c_reg <= sw_c_reg + CW'(1);
            end
        end
        if (cmd.src_grid) begin
            p_r_reg <= src_r;
            p_c_reg <= src_c;
        end
        if (cmd.pop_data) begin
            b_d_reg <= queue_q[QEW-1:RW+CW];
            b_r_reg <= queue_q[RW+CW-1:CW];
            b_c_reg <= queue_q[CW-1:0];
        end
        if (cmd.nb && k_reg < 3'd4) begin
            p_r_reg <= nr;
            p_c_reg <= nc;
        end
    end

    assign status.first        = first_reg;
    assign status.scan_done    = (idx_reg >= rc_reg) && !pend_reg;
    assign status.out_free     = !m_valid_reg || m_tready;
    assign status.need_rebuild = (phase_reg == '0) || (32'(rc_reg) >= MAX_RECENT);
    assign status.sweep_done   = sw_end_reg && !pend_reg;
    assign status.src_last     = (idx_reg == rc_reg);
    assign status.q_nonempty   = (head_reg < tail_reg);
    assign status.nb_done      = (k_reg == 3'd4) && !pend_reg;

    assign m_tvalid   = m_valid_reg;
    assign m_distance = m_data_reg;

endmodule

### hdl/online_nearest_point_distance_core.sv
// top level of the online nearest point distance core
// instantiates onpd_ctrl and onpd_dp, uses onpd_pkg
//
// channel   direction  payload
// s_        in         tuser: start_req; tdata: row [5:0], col [11:6]
// m_        out        tdata: distance [6:0]
// cfg_      in         data: rebuild_interval [6:0]
//
// an item without rebuild is bound by the one-read-per-cycle scan of the
// recent point list
// a rebuild adds a sweep over the grid, a read, grid read and check per recent
// source and a bfs over the grid cells, paced by the single grid memory port
// reset is synchronous; the grid needs no clearing pass, the first point
// of a set rebuilds it; s_tready is low while an item is in work, and a
// result waiting on m_tready stalls only the next result
module online_nearest_point_distance_core #(
    parameter int GRID_ROWS  = onpd_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS  = onpd_pkg::GRID_COLS_DEF,
    parameter int MAX_RECENT = onpd_pkg::MAX_RECENT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [onpd_pkg::S_TDATA_W-1:0]     s_tdata,   // row, col, zero pad
    input  logic                               s_tuser,   // start_req
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [onpd_pkg::M_TDATA_W-1:0]     m_tdata,   // distance, zero pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [onpd_pkg::IVAL_W-1:0]        cfg_data   // rebuild_interval
);
    import onpd_pkg::*;

    onpd_cmd_t    cmd;
    onpd_status_t status;
    logic [DIST_OUT_W-1:0] distance;

    assign cfg_ready = 1'b1;
    assign m_tdata = {{(M_TDATA_W - DIST_OUT_W){1'b0}}, distance};

    onpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    onpd_dp #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .MAX_RECENT (MAX_RECENT)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_start   (s_tuser),
        .in_row     (s_tdata[COORD_W-1:0]),
        .in_col     (s_tdata[2*COORD_W-1:COORD_W]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_distance (distance)
    );

endmodule

### tb/tb_online_nearest_point_distance_core.sv
// self-checking testbench for online_nearest_point_distance_core: a queue-fed
// stream driver, a result monitor and a bfs-based distance predictor
// depends on onpd_pkg and the core rtl only
module tb_online_nearest_point_distance_core;
    import onpd_pkg::*;

    localparam int ROWS    = 64;
    localparam int COLS    = 64;
    localparam int CELLS   = ROWS * COLS;
    localparam int RECENT  = 64;
    localparam int UNREACH = 'hFFFF;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        bit                 start_req;
        bit [COORD_W-1:0]   row;
        bit [COORD_W-1:0]   col;
    } point_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IVAL_W-1:0]    cfg_data = '0;

    online_nearest_point_distance_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    point_t                pending_pts[$];
    point_t                cur_pt;
    bit [DIST_OUT_W-1:0]   expected_dist[$];
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    error_cnt = 0;
    longint                cycle_cnt = 0;

    // predictor state
    int                    grid_dist[CELLS];
    int                    recent_cells[RECENT];
    int                    recent_cnt = 0;
    int                    phase_cnt = 0;
    bit                    set_open = 1'b0;
    int                    ival_model = IVAL_RESET;
    bit [COORD_W-1:0]      last_row = '0;
    bit [COORD_W-1:0]      last_col = '0;

    function automatic void regrow_grid(int cur, bit keep_folded);
        int bfs_q[$];
        int node, r, c, nd;
        int nbrs[$];
        for (int i = 0; i < CELLS; i++) begin
            if (keep_folded && grid_dist[i] == 0) bfs_q.insert(bfs_q.size(), i);
            else grid_dist[i] = UNREACH;
        end
        for (int i = 0; i < recent_cnt; i++) begin
            if (grid_dist[recent_cells[i]] != 0) begin
                grid_dist[recent_cells[i]] = 0;
                bfs_q.insert(bfs_q.size(), recent_cells[i]);
            end
        end
        if (grid_dist[cur] != 0) begin
            grid_dist[cur] = 0;
            bfs_q.insert(bfs_q.size(), cur);
        end
        while (bfs_q.size() > 0) begin
            node = bfs_q.pop_front();
            r = node / COLS;
            c = node % COLS;
            nd = grid_dist[node] + 1;
            nbrs.delete();
            if (r > 0) nbrs.insert(nbrs.size(), node - COLS);
            if (c + 1 < COLS) nbrs.insert(nbrs.size(), node + 1);
            if (r + 1 < ROWS) nbrs.insert(nbrs.size(), node + COLS);
            if (c > 0) nbrs.insert(nbrs.size(), node - 1);
            foreach (nbrs[k]) begin
                if (grid_dist[nbrs[k]] == UNREACH) begin
                    grid_dist[nbrs[k]] = nd;
                    bfs_q.insert(bfs_q.size(), nbrs[k]);
                end
            end
        end
        recent_cnt = 0;
    endfunction

    function automatic void predict_distance(point_t p);
        int cur, best, d, pr, pc, lim, nxt;
        bit first;
        cur = p.row * COLS + p.col;
        lim = (ival_model == 0) ? 1 : (ival_model > RECENT ? RECENT : ival_model);
        first = p.start_req || !set_open;
        if (first) begin
            recent_cnt = 0;
            phase_cnt = 0;
        end else begin
            best = grid_dist[cur];
            for (int i = 0; i < recent_cnt; i++) begin
                pr = recent_cells[i] / COLS;
                pc = recent_cells[i] % COLS;
                d = (pr > p.row ? pr - p.row : p.row - pr) + (pc > p.col ? pc - p.col : p.col - pc);
                if (d < best) best = d;
            end
            if (best > DIST_OUT_MAX) best = DIST_OUT_MAX;
            expected_dist.insert(expected_dist.size(), best[DIST_OUT_W-1:0]);
        end
        if (phase_cnt == 0 || recent_cnt >= RECENT) begin
            regrow_grid(cur, !first);
        end else begin
            recent_cells[recent_cnt] = cur;
            recent_cnt++;
        end
        set_open = 1'b1;
        nxt = phase_cnt + 1;
        phase_cnt = (nxt >= lim) ? 0 : (nxt & 63);
    endfunction

    // driver: at most one assignment to s_tvalid per edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_distance(cur_pt);
            if (!s_tvalid || s_tready) begin
                if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_pt = pending_pts.pop_front();
                    s_tdata <= {{(S_TDATA_W - 2*COORD_W){1'b0}}, cur_pt.col, cur_pt.row};
                    s_tuser <= cur_pt.start_req;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge aclk) begin
        bit [DIST_OUT_W-1:0] exp_d;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (expected_dist.size() == 0) begin
                    $error("unexpected result transfer: distance actual %0d",
                           m_tdata[DIST_OUT_W-1:0]);
                    error_cnt++;
                end else begin
                    exp_d = expected_dist.pop_front();
                    if (m_tdata[DIST_OUT_W-1:0] !== exp_d) begin
                        $error("distance: expected %0d actual %0d", exp_d,
                               m_tdata[DIST_OUT_W-1:0]);
                        error_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_point(bit s, int r, int c);
        point_t p;
        p.start_req = s;
        p.row = r[COORD_W-1:0];
        p.col = c[COORD_W-1:0];
        pending_pts.insert(pending_pts.size(), p);
        last_row = p.row;
        last_col = p.col;
    endtask

    // mostly continuing sets; nearby points, corners and repeats mixed in
    task automatic add_random_points(int n);
        int kind, r, c;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            r = $urandom_range(63);
            c = $urandom_range(63);
            if (kind == 6 || kind == 7) begin
                r = int'(last_row) + $urandom_range(6) - 3;
                c = int'(last_col) + $urandom_range(6) - 3;
                r = r < 0 ? 0 : (r > 63 ? 63 : r);
                c = c < 0 ? 0 : (c > 63 ? 63 : c);
            end else if (kind == 8) begin
                r = $urandom_range(1) * 63;
                c = $urandom_range(1) * 63;
            end else if (kind == 9) begin
                r = last_row;
                c = last_col;
            end
            add_point($urandom_range(149) == 0, r, c);
        end
    endtask

    // the block may still be rebuilding after the last result, so also wait for s_tready
    task automatic wait_drained();
        while (pending_pts.size() > 0 || s_tvalid || expected_dist.size() > 0)
            @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_interval(int v);
        wait_drained();
        cfg_data <= v[IVAL_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ival_model = v;
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset interval, corners, repeats, restart of a set
        add_point(1'b0, 0, 0);
        add_point(1'b0, 63, 63);
        add_point(1'b0, 0, 63);
        add_point(1'b0, 63, 0);
        add_point(1'b0, 63, 63);
        add_point(1'b0, 31, 32);
        add_point(1'b0, 42, 21);
        add_point(1'b0, 0, 0);
        add_point(1'b0, 1, 1);
        add_point(1'b0, 21, 42);
        add_point(1'b1, 32, 32);
        add_point(1'b0, 32, 33);
        add_point(1'b0, 0, 0);
        add_point(1'b1, 63, 63);
        add_point(1'b0, 63, 63);
        add_point(1'b0, 0, 0);

        // interval one: rebuild at every point
        write_interval(1);
        set_idling(1);
        add_point(1'b0, 10, 10);
        add_point(1'b0, 20, 5);
        add_point(1'b0, 10, 11);
        add_point(1'b0, 63, 0);

        // interval zero behaves as one
        write_interval(0);
        set_idling(2);
        add_point(1'b1, 5, 5);
        add_point(1'b0, 6, 6);
        add_point(1'b0, 5, 5);

        write_interval(64);
        set_idling(0);
        add_random_points(120);
        // pause the sender until the block is drained
        wait_drained();
        set_idling(3);
        add_random_points(60);

        // above the recent capacity: acts as the capacity
        write_interval(127);
        set_idling(1);
        add_random_points(130);

        // lowered mid-set, no restart
        write_interval(3);
        set_idling(2);
        add_random_points(50);

        write_interval(40);
        set_idling(3);
        add_random_points(130);

        write_interval(64);
        set_idling(0);
        add_random_points(110);

        wait_drained();
        repeat (100) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
hdl/onpd_pkg.sv
hdl/onpd_ctrl.sv
hdl/onpd_dp.sv
hdl/online_nearest_point_distance_core.sv
tb/tb_online_nearest_point_distance_core.sv
